[hw/rtl/pcx_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the PCX run-length palette decoder.
// Depends on nothing; used by pcx_rle_palette_decoder.
package pcx_pkg;

	localparam int CFG_DATA_W = 17;
	localparam int CFG_ADDR_W = 3;

	// register indexes of the configuration port
	localparam logic [CFG_ADDR_W-1:0] REG_LINE_PITCH      = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_TRANSPARENT_EN  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_PALETTE_ENTRIES = 3'd4;

	// input operations
	localparam logic OP_PALETTE = 1'b0;
	localparam logic OP_CODE    = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_PIXEL        = 2'd0;
	localparam logic [1:0] STATUS_RUN_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_BAD_INDEX    = 2'd2;

	localparam logic [1:0] RUN_MARK          = 2'b11;
	localparam logic [7:0] TRANSPARENT_INDEX = 8'hff;
	localparam logic [7:0] ALPHA_OPAQUE      = 8'hff;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  palette_index;
		logic [23:0] palette_rgb;
		logic [7:0]  code_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic [1:0]  status;
		logic        last;
	} out_word_t;

endpackage

[hw/rtl/pcx_rle_palette_decoder.sv]
`timescale 1ns / 1ps
// PCX run-length decoder with palette lookup: top level.
// A palette write or a run header is taken in the idle state. A code byte that
// yields words passes through a check state, then emits one word per cycle
// from the shared position counter and end compare while the output is not stalled;
// a byte that yields no word returns to idle after the check. Ignored bytes are taken in the idle state.
// Reset clears control state and sets configuration to its defaults; the palette RAM is not cleared.
module pcx_rle_palette_decoder #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcx_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [pcx_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pcx_pkg::in_word_t                   in_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pcx_pkg::out_word_t                  out_word
);
	import pcx_pkg::*;

	localparam int IDX_W = $clog2(PALETTE_DEPTH);
	localparam logic [8:0] DEPTH_9 = 9'(PALETTE_DEPTH);

	// configuration
	logic [15:0] pitch_q;
	logic [16:0] width_q;
	logic [16:0] height_q;
	logic        transp_q;
	logic [8:0]  entries_q;

	// decode state
	state_t      state_q, state_d;
	logic        run_pend_q;
	logic [5:0]  run_len_q;
	logic [15:0] pos_q;
	logic [16:0] line_q;
	logic        err_q;

	// per-byte work registers
	logic [7:0]  byte_q;
	logic [5:0]  cnt_q;
	logic [15:0] x_q;
	logic [16:0] end_q;
	logic [15:0] y_q;
	logic [1:0]  kind_q;
	logic [23:0] rgb_q;

	logic [23:0] pal_mem [PALETTE_DEPTH];

	logic      out_valid_q;
	out_word_t out_q;

	// handshake and decisions
	logic        in_fire;
	logic        code_live;
	logic        is_header;
	logic [5:0]  take_cnt;
	logic        start_eval;
	logic        pal_we;
	logic        slot_free;
	logic        emit_fire;
	logic        emit_last;
	logic [16:0] x_next;

	// evaluation datapath
	logic [15:0] pitch_eff;
	logic [16:0] new_pos;
	logic        overflow;
	logic        has_pix;
	logic [8:0]  limit;
	logic        bad_index;
	logic        is_transp;

	assign in_fire   = in_valid && in_ready;
	assign code_live = !err_q && (line_q < height_q);
	assign is_header = !run_pend_q && (in_word.code_byte[7:6] == RUN_MARK);
	assign take_cnt  = run_pend_q ? run_len_q : 6'd1;
	assign start_eval = in_fire && (in_word.op == OP_CODE) && code_live && !is_header &&
		(take_cnt != 6'd0);
	assign pal_we = in_fire && (in_word.op == OP_PALETTE) &&
		({1'b0, in_word.palette_index} < DEPTH_9);

	assign pitch_eff = (pitch_q == 16'd0) ? 16'd1 : pitch_q;
	assign new_pos   = {1'b0, pos_q} + {11'd0, cnt_q};
	assign overflow  = new_pos > {1'b0, pitch_eff};
	assign has_pix   = {1'b0, pos_q} < width_q;
	assign limit     = (entries_q < DEPTH_9) ? entries_q : DEPTH_9;
	assign bad_index = {1'b0, byte_q} >= limit;
	assign is_transp = transp_q && (byte_q == TRANSPARENT_INDEX);

	assign slot_free = !out_valid_q || out_ready;
	assign x_next    = {1'b0, x_q} + 17'd1;
	assign emit_last = (kind_q != STATUS_PIXEL) || (x_next == end_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_eval) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (overflow || has_pix) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit_fire && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			ST_IDLE: in_ready  = 1'b1;
			ST_EVAL: in_ready  = 1'b0;
			ST_EMIT: emit_fire = slot_free;
			default: in_ready  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q   <= 16'd1;
			width_q   <= 17'd1;
			height_q  <= 17'd1;
			transp_q  <= 1'b0;
			entries_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LINE_PITCH:      pitch_q   <= cfg_wdata[15:0];
				REG_IMAGE_WIDTH:     width_q   <= cfg_wdata;
				REG_IMAGE_HEIGHT:    height_q  <= cfg_wdata;
				REG_TRANSPARENT_EN:  transp_q  <= cfg_wdata[0];
				REG_PALETTE_ENTRIES: entries_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			run_pend_q <= 1'b0;
			run_len_q  <= 6'd0;
			pos_q      <= 16'd0;
			line_q     <= 17'd0;
			err_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && (in_word.op == OP_CODE) && code_live) begin
				if (is_header) begin
					run_pend_q <= 1'b1;
					run_len_q  <= in_word.code_byte[5:0];
				end else begin
					run_pend_q <= 1'b0;
				end
			end
			if (state_q == ST_EVAL) begin
				if (overflow || (has_pix && bad_index)) begin
					err_q <= 1'b1;
				end else if (new_pos >= {1'b0, pitch_eff}) begin
					// line done: wrap to the next scanline
					pos_q  <= 16'd0;
					line_q <= line_q + 17'd1;
				end else begin
					pos_q <= new_pos[15:0];
				end
			end
		end
	end

	// per-byte work registers, payload only
	always_ff @(posedge clk) begin
		if (start_eval) begin
			byte_q <= in_word.code_byte;
			cnt_q  <= take_cnt;
		end
		if (state_q == ST_EVAL) begin
			x_q   <= pos_q;
			y_q   <= line_q[15:0];
			end_q <= (new_pos < width_q) ? new_pos : width_q;
			if (overflow) begin
				kind_q <= STATUS_RUN_OVERFLOW;
			end else if (bad_index) begin
				kind_q <= STATUS_BAD_INDEX;
			end else begin
				kind_q <= STATUS_PIXEL;
			end
		end else if (emit_fire) begin
			x_q <= x_next[15:0];
		end
	end

	// palette RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[in_word.palette_index[IDX_W-1:0]] <= in_word.palette_rgb;
		end
		if (start_eval) begin
			rgb_q <= pal_mem[in_word.code_byte[IDX_W-1:0]];
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_q.pixel_x <= x_q;
			out_q.pixel_y <= y_q;
			out_q.status  <= kind_q;
			out_q.last    <= emit_last;
			if (kind_q != STATUS_PIXEL || is_transp) begin
				out_q.red   <= 8'd0;
				out_q.green <= 8'd0;
				out_q.blue  <= 8'd0;
				out_q.alpha <= 8'd0;
			end else begin
				out_q.red   <= rgb_q[7:0];
				out_q.green <= rgb_q[15:8];
				out_q.blue  <= rgb_q[23:16];
				out_q.alpha <= ALPHA_OPAQUE;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag cleared without reset");

	a_err_word_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.status != STATUS_PIXEL) |-> (out_word.last && err_q))
		else $error("error word not final or error not latched");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && kind_q == STATUS_PIXEL) |-> ({1'b0, x_q} < end_q))
		else $error("pixel column past end of visible span");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |=> (state_q != ST_IDLE || !out_valid || out_word.last))
		else $error("check cycle returned to idle with a partial run");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the PCX run-length palette decoder.
// Depends on pcx_pkg and pcx_rle_palette_decoder; a scoreboard class predicts pixel words.

import pcx_pkg::*;

typedef logic [CFG_DATA_W-1:0] cfg_data_t;

class pixel_scoreboard;
	out_word_t   expected_pixels[$];
	logic [23:0] colors[256];
	bit          run_pending;
	logic [5:0]  run_count;
	int unsigned line_pos;
	int unsigned line_num;
	bit          error_latched;
	int unsigned pitch_reg;
	int unsigned width_reg;
	int unsigned height_reg;
	int unsigned entries_reg;
	bit          transp_reg;
	int unsigned mismatches;
	int unsigned pixels_checked;

	function new();
		foreach (colors[i]) colors[i] = '0;
		pitch_reg = 1;
		width_reg = 1;
		height_reg = 1;
		entries_reg = 256;
		transp_reg = 1'b0;
		run_pending = 1'b0;
		run_count = '0;
		line_pos = 0;
		line_num = 0;
		error_latched = 1'b0;
		mismatches = 0;
		pixels_checked = 0;
	endfunction

	function void write_reg(logic [CFG_ADDR_W-1:0] addr, cfg_data_t data);
		case (addr)
			REG_LINE_PITCH:      pitch_reg = data[15:0];
			REG_IMAGE_WIDTH:     width_reg = data[16:0];
			REG_IMAGE_HEIGHT:    height_reg = data[16:0];
			REG_TRANSPARENT_EN:  transp_reg = data[0];
			REG_PALETTE_ENTRIES: entries_reg = data[8:0];
			default: ;
		endcase
	endfunction

	function int unsigned pitch_now();
		return (pitch_reg == 0) ? 1 : pitch_reg;
	endfunction

	function int unsigned room_left();
		return (line_pos < pitch_now()) ? pitch_now() - line_pos : 0;
	endfunction

	function int unsigned index_limit();
		return (entries_reg < 256) ? entries_reg : 256;
	endfunction

	function out_word_t make_word(logic [23:0] rgb, logic [7:0] a, int unsigned x,
			logic [1:0] st);
		out_word_t w;
		w.red     = rgb[7:0];
		w.green   = rgb[15:8];
		w.blue    = rgb[23:16];
		w.alpha   = a;
		w.pixel_x = x[15:0];
		w.pixel_y = line_num[15:0];
		w.status  = st;
		w.last    = 1'b0;
		return w;
	endfunction

	// note an accepted word and queue the pixel words it decodes to
	function void decode_input(in_word_t w);
		out_word_t   pix[$];
		int unsigned count;
		int unsigned x;
		logic [7:0]  b;
		if (w.op == OP_PALETTE) begin
			colors[w.palette_index] = w.palette_rgb;
			return;
		end
		if (error_latched || line_num >= height_reg)
			return;
		b = w.code_byte;
		if (run_pending) begin
			run_pending = 1'b0;
			count = run_count;
		end else if (b[7:6] == RUN_MARK) begin
			run_pending = 1'b1;
			run_count = b[5:0];
			return;
		end else begin
			count = 1;
		end
		if (count == 0)
			return;
		if (count > room_left()) begin
			error_latched = 1'b1;
			pix.push_back(make_word('0, '0, line_pos, STATUS_RUN_OVERFLOW));
		end else begin
			for (int unsigned i = 0; i < count; i++) begin
				x = line_pos + i;
				if (x >= width_reg)
					continue;
				// range check wins over transparency
				if (b >= index_limit()) begin
					error_latched = 1'b1;
					pix.push_back(make_word('0, '0, x, STATUS_BAD_INDEX));
					break;
				end
				if (b == TRANSPARENT_INDEX && transp_reg)
					pix.push_back(make_word('0, '0, x, STATUS_PIXEL));
				else
					pix.push_back(make_word(colors[b], ALPHA_OPAQUE, x, STATUS_PIXEL));
			end
			if (!error_latched) begin
				line_pos += count;
				if (line_pos >= pitch_now()) begin
					line_pos = 0;
					line_num++;
				end
			end
		end
		if (pix.size() > 0)
			pix[pix.size()-1].last = 1'b1;
		foreach (pix[i]) expected_pixels.push_back(pix[i]);
	endfunction

	function string show(out_word_t w);
		return $sformatf("rgba %02h %02h %02h %02h x %0d y %0d status %0d last %0d",
			w.red, w.green, w.blue, w.alpha, w.pixel_x, w.pixel_y, w.status, w.last);
	endfunction

	function void check_output(out_word_t got);
		out_word_t want;
		pixels_checked++;
		if (expected_pixels.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: %s", show(got));
			return;
		end
		want = expected_pixels.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("word mismatch, expected %s", show(want));
				$display("               actual   %s", show(got));
			end
		end
	endfunction
endclass

module tb_top;

	typedef enum int {
		END_RUN_OVERFLOW,
		END_SHORT_PITCH,
		END_BAD_INDEX
	} end_case_t;

	localparam int         QUIET_LIMIT = 4000;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         RANDOM_WORDS = 70;
	localparam int         PHASE_GROUPS = 10;
	localparam logic [7:0] LITERAL_MAX = 8'hbf;
	localparam logic [7:0] ZERO_RUN = 8'hc0;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	cfg_data_t cfg_wdata;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;

	pixel_scoreboard sb = new();

	bit          idle_on = 1'b1;
	int          stall_left = 0;
	int          quiet_cycles = 0;
	int unsigned words_sent = 0;
	int unsigned phases = 0;
	end_case_t   end_kind;

	pcx_rle_palette_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	always #2 clk = ~clk;

	// check every accepted pixel word, stall the output in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_output(out_word);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (in_valid || sb.expected_pixels.size() != 0) begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("stalled for %0d cycles", quiet_cycles);
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

	task automatic send_word(in_word_t w);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		sb.decode_input(w);
		words_sent++;
	endtask

	task automatic send_code(logic [7:0] b);
		in_word_t w;
		w.op = OP_CODE;
		w.palette_index = 8'($urandom);
		w.palette_rgb = 24'($urandom);
		w.code_byte = b;
		send_word(w);
	endtask

	task automatic send_palette(logic [7:0] idx, logic [23:0] rgb);
		in_word_t w;
		w.op = OP_PALETTE;
		w.palette_index = idx;
		w.palette_rgb = rgb;
		w.code_byte = 8'($urandom);
		send_word(w);
	endtask

	// drop valid, wait for every pixel word, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, int unsigned value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= cfg_data_t'(value);
		@(posedge clk);
		sb.write_reg(addr, cfg_data_t'(value));
	endtask

	task automatic set_config(int unsigned pitch, int unsigned width, int unsigned height,
			bit transp, int unsigned entries);
		settle();
		write_reg(REG_LINE_PITCH, pitch);
		write_reg(REG_IMAGE_WIDTH, width);
		write_reg(REG_IMAGE_HEIGHT, height);
		write_reg(REG_TRANSPARENT_EN, transp);
		write_reg(REG_PALETTE_ENTRIES, entries);
		cfg_we <= 1'b0;
		phases++;
	endtask

	function automatic logic [7:0] pick_index(int unsigned limit, bit literal);
		int unsigned hi;
		hi = limit - 1;
		if (literal && hi > LITERAL_MAX)
			hi = LITERAL_MAX;
		return 8'($urandom_range(0, hi));
	endfunction

	// one literal, one run, a zero run or a palette write, always in range
	task automatic send_random_group();
		int unsigned roll;
		int unsigned cmax;
		int unsigned count;
		logic [7:0]  data;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			send_palette(8'($urandom), 24'($urandom));
		end else if (roll < 16) begin
			send_code(ZERO_RUN);
			send_code(8'($urandom));
		end else if (roll < 55) begin
			send_code(pick_index(sb.index_limit(), 1'b1));
		end else begin
			cmax = (sb.room_left() < 63) ? sb.room_left() : 63;
			if ($urandom_range(0, 9) < 7)
				count = $urandom_range(1, (cmax < 8) ? cmax : 8);
			else
				count = $urandom_range(1, cmax);
			if (sb.index_limit() == 256 && $urandom_range(0, 5) == 0)
				data = TRANSPARENT_INDEX;
			else
				data = pick_index(sb.index_limit(), 1'b0);
			send_code({RUN_MARK, 6'(count)});
			if ($urandom_range(0, 9) == 0)
				send_palette(8'($urandom), 24'($urandom));
			send_code(data);
		end
	endtask

	task automatic random_phase(bit huge);
		int unsigned pitch;
		int unsigned width;
		int unsigned entries;
		if (huge)
			pitch = 65535;
		else if ($urandom_range(0, 1) == 0)
			pitch = $urandom_range(1, 16);
		else
			pitch = $urandom_range(17, 90);
		// never shrink the line below the current column
		if (pitch <= sb.line_pos)
			pitch = sb.line_pos + $urandom_range(1, 16);
		case ($urandom_range(0, 5))
			0:       width = 1;
			1:       width = 65536;
			default: width = $urandom_range(1, pitch + 4);
		endcase
		case ($urandom_range(0, 4))
			0, 1:    entries = 256;
			2:       entries = 16;
			default: entries = $urandom_range(16, 256);
		endcase
		set_config(pitch, width, 65536, 1'($urandom_range(0, 1)), entries);
		idle_on = ($urandom_range(0, 3) != 0);
	endtask

	initial begin
		int unsigned random_start;
		int unsigned groups;
		int unsigned count;
		int unsigned entries;
		bit          excursion_done;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_word = '0;
		out_ready = 1'b0;
		excursion_done = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// load the whole palette before any pixel can read it
		set_config(8, 6, 65536, 1'b1, 256);
		for (int i = 0; i < 256; i++) begin
			if (i == 0)
				send_palette(8'(i), 24'h000000);
			else if (i == 1)
				send_palette(8'(i), 24'hffffff);
			else
				send_palette(8'(i), 24'($urandom));
		end

		// literals at both ends, transparent run, zero run, padding run
		send_code(8'h00);
		send_code(8'h3f);
		send_code(LITERAL_MAX);
		send_code(8'h80);
		send_code({RUN_MARK, 6'd2});
		send_code(TRANSPARENT_INDEX);
		send_code(ZERO_RUN);
		send_code(8'h5a);
		send_code({RUN_MARK, 6'd2});
		send_code(8'h80);
		// palette write between a run header and its data
		send_code({RUN_MARK, 6'd4});
		send_palette(8'h05, 24'h123456);
		send_code(8'h05);
		send_code(8'h01);
		send_code(8'h00);

		// longest run, opaque index 255
		set_config(70, 65536, 65536, 1'b0, 256);
		send_code({RUN_MARK, 6'd63});
		send_code(TRANSPARENT_INDEX);
		send_code({RUN_MARK, 6'd1});
		send_code({RUN_MARK, 6'd1});

		// zero pitch and zero width: every byte is padding
		set_config(0, 0, 65536, 1'b0, 16);
		send_code(8'h10);
		send_code({RUN_MARK, 6'd1});
		send_code(8'h30);

		// zero height ignores everything, then stop after two more lines
		set_config(1, 1, 0, 1'b1, 16);
		send_code({RUN_MARK, 6'd5});
		send_code(8'h07);
		set_config(1, 1, sb.line_num + 2, 1'b1, 16);
		send_code(8'h0f);
		send_code(8'h0e);
		send_code(8'h0d);

		random_start = words_sent;
		groups = 0;
		random_phase(1'b1);
		while (words_sent - random_start < RANDOM_WORDS) begin
			if (groups >= PHASE_GROUPS) begin
				groups = 0;
				if (!excursion_done && words_sent - random_start > RANDOM_WORDS / 2) begin
					// run off the bottom of the image, then open it again
					excursion_done = 1'b1;
					set_config(sb.pitch_reg, sb.width_reg, sb.line_num + 1, sb.transp_reg,
						sb.entries_reg);
					repeat (15) send_random_group();
				end
				random_phase(1'b0);
			end
			send_random_group();
			groups++;
		end

		// closing error case, no idling from here on
		idle_on = 1'b0;
		end_kind = end_case_t'($urandom_range(0, 2));
		case (end_kind)
			END_RUN_OVERFLOW: begin
				set_config(sb.line_pos + $urandom_range(1, 40), 65536, 65536,
					1'($urandom_range(0, 1)), 256);
				count = sb.room_left() + $urandom_range(1, 63 - sb.room_left());
				send_code({RUN_MARK, 6'(count)});
				send_code(8'($urandom));
			end
			END_SHORT_PITCH: begin
				set_config(sb.line_pos + $urandom_range(5, 12), $urandom_range(1, 65536),
					65536, 1'b0, 256);
				send_code(pick_index(256, 1'b1));
				// pitch at or below the column: a plain literal overflows
				set_config($urandom_range(0, sb.line_pos), sb.width_reg, 65536, 1'b0, 256);
				send_code(pick_index(256, 1'b1));
			end
			default: begin
				entries = $urandom_range(16, 255);
				set_config(sb.line_pos + $urandom_range(64, 200), 65536, 65536, 1'b1,
					entries);
				send_code({RUN_MARK, 6'($urandom_range(1, 63))});
				send_code(8'($urandom_range(entries, 255)));
			end
		endcase
		// decoder is latched now: code bytes drop, palette writes still land
		repeat (20) send_random_group();

		settle();
		$display("covered %0d input words, %0d pixel words, %0d register settings",
			words_sent, sb.pixels_checked, phases);
		$display("closing error case %s, %0d mismatches", end_kind.name(), sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
